// ===== sv/smmat_pkg.sv =====
`default_nettype none

package smmat_pkg;

	// field widths
	localparam int SAMPLE_BITS = 10;
	localparam int COUNT_BITS  = 22;
	localparam int FRAC_BITS   = 4;
	localparam int SUM_BITS    = 32;
	localparam int ACTION_BITS = 2;
	localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
	localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
	localparam int STEP_BITS   = $clog2(DIV_BITS + 1);

	// saturation limits
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

	// action codes; the unused code acts as a plain sample
	localparam logic [ACTION_BITS-1:0] ACT_SAMPLE  = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_HIDE    = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_RESTART = 2'd2;

	// job queue depth
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// one classified item, statistics already updated
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [SAMPLE_BITS-1:0] maximum;
		logic [SAMPLE_BITS-1:0] minimum;
		logic                   shown;
		logic [SUM_BITS-1:0]    sum;
		logic [COUNT_BITS-1:0]  count;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ===== sv/smmat_queue.sv =====
`default_nettype none

module smmat_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  smmat_pkg::job_t     push_data,
	input  wire                 pop,
	output smmat_pkg::job_t     pop_data,
	output smmat_pkg::qstat_t   stat
);

	smmat_pkg::job_t                     entry_q [smmat_pkg::QUEUE_DEPTH];
	logic [smmat_pkg::QUEUE_AW-1:0]      wr_ptr_q;
	logic [smmat_pkg::QUEUE_AW-1:0]      rd_ptr_q;
	logic [smmat_pkg::QUEUE_AW:0]        fill_q;
	logic                                do_push;
	logic                                do_pop;

	assign stat.full  = (fill_q == (smmat_pkg::QUEUE_AW + 1)'(smmat_pkg::QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = entry_q[rd_ptr_q];

	// store pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/smmat_front.sv =====
`default_nettype none

module smmat_front (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     accept,
	input  wire  [smmat_pkg::SAMPLE_BITS-1:0]       sample,
	input  wire  [smmat_pkg::ACTION_BITS-1:0]       action,
	output smmat_pkg::job_t                         job
);

	logic [smmat_pkg::SAMPLE_BITS-1:0] max_q;
	logic [smmat_pkg::SAMPLE_BITS-1:0] min_q;
	logic [smmat_pkg::SUM_BITS-1:0]    sum_q;
	logic [smmat_pkg::COUNT_BITS-1:0]  count_q;
	logic                              show_q;

	logic                              restart;
	logic                              hide;
	logic [smmat_pkg::SAMPLE_BITS-1:0] base_max;
	logic [smmat_pkg::SAMPLE_BITS-1:0] base_min;
	logic [smmat_pkg::SUM_BITS-1:0]    base_sum;
	logic [smmat_pkg::COUNT_BITS-1:0]  base_count;
	logic [smmat_pkg::SUM_BITS:0]      sum_add;

	// classify the action
	assign restart = (action == smmat_pkg::ACT_RESTART);
	assign hide    = (action == smmat_pkg::ACT_HIDE);

	// start from cleared statistics on restart
	assign base_max   = restart ? '0 : max_q;
	assign base_min   = restart ? sample : min_q;
	assign base_sum   = restart ? '0 : sum_q;
	assign base_count = restart ? '0 : count_q;

	assign sum_add = {1'b0, base_sum}
		+ {{(smmat_pkg::SUM_BITS + 1 - smmat_pkg::SAMPLE_BITS){1'b0}}, sample};

	// build updated statistics for this item
	always_comb begin
		job.sample  = sample;
		job.maximum = (sample > base_max) ? sample : base_max;
		job.minimum = (sample < base_min) ? sample : base_min;
		if (restart) begin
			job.shown = 1'b1;
		end else if (hide) begin
			job.shown = 1'b0;
		end else begin
			job.shown = show_q;
		end
		if (base_count != smmat_pkg::COUNT_MAX) begin
			job.count = base_count + 1'b1;
			job.sum   = sum_add[smmat_pkg::SUM_BITS] ? smmat_pkg::SUM_MAX
				: sum_add[smmat_pkg::SUM_BITS-1:0];
		end else begin
			job.count = base_count;
			job.sum   = base_sum;
		end
	end

	// hold running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			min_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
			show_q  <= 1'b0;
		end else if (accept) begin
			max_q   <= job.maximum;
			min_q   <= job.minimum;
			sum_q   <= job.sum;
			count_q <= job.count;
			show_q  <= job.shown;
		end
	end

endmodule

`default_nettype wire

// ===== sv/smmat_back.sv =====
`default_nettype none

module smmat_back (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  smmat_pkg::qstat_t                       stat,
	input  smmat_pkg::job_t                         job,
	output logic                                    pop,
	output logic                                    result_valid,
	input  wire                                     result_stall,
	output logic [smmat_pkg::SAMPLE_BITS-1:0]       current_sample,
	output logic [smmat_pkg::AVG_BITS-1:0]          average_fixed,
	output logic [smmat_pkg::SAMPLE_BITS-1:0]       maximum,
	output logic [smmat_pkg::SAMPLE_BITS-1:0]       minimum,
	output logic                                    stats_shown
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                          state_q;
	logic [smmat_pkg::STEP_BITS-1:0]     step_q;
	logic [smmat_pkg::DIV_BITS-1:0]      dvd_q;
	logic [smmat_pkg::DIV_BITS-1:0]      quo_q;
	logic [smmat_pkg::COUNT_BITS-1:0]    rem_q;
	logic [smmat_pkg::COUNT_BITS-1:0]    div_q;
	logic [smmat_pkg::SAMPLE_BITS-1:0]   sample_q;
	logic [smmat_pkg::SAMPLE_BITS-1:0]   max_q;
	logic [smmat_pkg::SAMPLE_BITS-1:0]   min_q;
	logic                                shown_q;
	logic                                valid_q;

	logic [smmat_pkg::COUNT_BITS:0]      rem_shift;
	logic [smmat_pkg::COUNT_BITS:0]      rem_diff;
	logic                                fits;
	logic                                load_out;

	assign pop      = (state_q == ST_IDLE) && !stat.empty;
	assign load_out = (state_q == ST_DONE) && (!valid_q || !result_stall);

	// one restoring division step
	assign rem_shift = {rem_q, dvd_q[smmat_pkg::DIV_BITS-1]};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign fits      = (rem_shift >= {1'b0, div_q});

	// sequence: take job, divide, hand to output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!stat.empty) begin
						state_q <= ST_DIV;
						step_q  <= smmat_pkg::STEP_BITS'(smmat_pkg::DIV_BITS);
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == smmat_pkg::STEP_BITS'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// load job and iterate the quotient
	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= job.sample;
			max_q    <= job.maximum;
			min_q    <= job.minimum;
			shown_q  <= job.shown;
			div_q    <= job.count;
			dvd_q    <= smmat_pkg::DIV_BITS'(job.sum) << smmat_pkg::FRAC_BITS;
			quo_q    <= '0;
			rem_q    <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[smmat_pkg::DIV_BITS-2:0], fits};
			rem_q <= fits ? rem_diff[smmat_pkg::COUNT_BITS-1:0]
				: rem_shift[smmat_pkg::COUNT_BITS-1:0];
		end
	end

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load_out || (valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			current_sample <= sample_q;
			average_fixed  <= quo_q[smmat_pkg::AVG_BITS-1:0];
			maximum        <= max_q;
			minimum        <= min_q;
			stats_shown    <= shown_q;
		end
	end

	assign result_valid = valid_q;

endmodule

`default_nettype wire

// ===== sv/sample_min_max_average_tracker_unit.sv =====
// Channel   Handshake                     Fields
// sample    sample_valid / sample_stall   sample[9:0], action[1:0]
// result    result_valid / result_stall   current_sample, average_fixed, maximum,
//                                         minimum, stats_shown
//
// In the back end each item is taken from the queue, runs through 36 steps of the
// restoring divider for the mean and is then loaded into the output register.
// The front updates the statistics in the accept cycle and queues up to two items.
// Reset clears the statistics (minimum and maximum 0, hidden) and empties the queue.
// sample_stall is high while the queue is full; a stalled result holds the back end
// only once its next division is done.
`default_nettype none

module sample_min_max_average_tracker_unit (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     sample_valid,
	output logic                                    sample_stall,
	input  wire  [smmat_pkg::SAMPLE_BITS-1:0]       sample,
	input  wire  [smmat_pkg::ACTION_BITS-1:0]       action,
	output logic                                    result_valid,
	input  wire                                     result_stall,
	output logic [smmat_pkg::SAMPLE_BITS-1:0]       current_sample,
	output logic [smmat_pkg::AVG_BITS-1:0]          average_fixed,
	output logic [smmat_pkg::SAMPLE_BITS-1:0]       maximum,
	output logic [smmat_pkg::SAMPLE_BITS-1:0]       minimum,
	output logic                                    stats_shown
);

	smmat_pkg::job_t    push_job;
	smmat_pkg::job_t    pop_job;
	smmat_pkg::qstat_t  q_stat;
	logic               accept;
	logic               pop;

	assign sample_stall = q_stat.full;
	assign accept       = sample_valid && !q_stat.full;

	// classify items and update statistics
	smmat_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.action (action),
		.job    (push_job)
	);

	// decouple front and back
	smmat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.stat      (q_stat)
	);

	// divide for the mean and drive results
	smmat_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.stat           (q_stat),
		.job            (pop_job),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.current_sample (current_sample),
		.average_fixed  (average_fixed),
		.maximum        (maximum),
		.minimum        (minimum),
		.stats_shown    (stats_shown)
	);

	// running maximum never falls below running minimum
	a_max_ge_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (maximum >= minimum))
		else $error("maximum below minimum");

	// mean stays within the sample range
	a_avg_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(average_fixed <= (smmat_pkg::AVG_BITS'(maximum) << smmat_pkg::FRAC_BITS)))
		else $error("mean above maximum");

	a_avg_ge_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(average_fixed >= (smmat_pkg::AVG_BITS'(minimum) << smmat_pkg::FRAC_BITS)))
		else $error("mean below minimum");

	// queue never reports full and empty together
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue status inconsistent");

endmodule

`default_nettype wire

// ===== verif/tracker_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, folds every accepted sample into its own copy of the
// running statistics and checks each result against the oldest expected one.
module tracker_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 sample_valid,
	input  wire                                 sample_stall,
	input  wire  [smmat_pkg::SAMPLE_BITS-1:0]   sample,
	input  wire  [smmat_pkg::ACTION_BITS-1:0]   action,
	input  wire                                 result_valid,
	input  wire                                 result_stall,
	input  wire  [smmat_pkg::SAMPLE_BITS-1:0]   current_sample,
	input  wire  [smmat_pkg::AVG_BITS-1:0]      average_fixed,
	input  wire  [smmat_pkg::SAMPLE_BITS-1:0]   maximum,
	input  wire  [smmat_pkg::SAMPLE_BITS-1:0]   minimum,
	input  wire                                 stats_shown,
	output int                                  error_count,
	output int                                  pending_count,
	output int                                  checked_count
);
	import smmat_pkg::*;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [AVG_BITS-1:0]    average;
		logic [SAMPLE_BITS-1:0] maximum;
		logic [SAMPLE_BITS-1:0] minimum;
		logic                   shown;
	} stats_t;

	// expected results, oldest first
	stats_t stats_q[$];

	// running statistics as the block should hold them
	logic [SAMPLE_BITS-1:0] run_max;
	logic [SAMPLE_BITS-1:0] run_min;
	logic [SUM_BITS-1:0]    run_sum;
	logic [COUNT_BITS-1:0]  run_count;
	logic                   run_shown;

	int errs = 0;
	int checked = 0;

	initial begin
		error_count = 0;
		pending_count = 0;
		checked_count = 0;
	end

	// apply the action, fold the sample in and return what the block should report
	function automatic stats_t fold_sample(input logic [SAMPLE_BITS-1:0] s,
		input logic [ACTION_BITS-1:0] a);
		logic [SUM_BITS:0]   wide_sum;
		logic [DIV_BITS-1:0] quotient;
		stats_t              r;
		case (a)
			ACT_HIDE: begin
				run_shown = 1'b0;
			end
			ACT_RESTART: begin
				run_max   = '0;
				run_min   = s;
				run_sum   = '0;
				run_count = '0;
				run_shown = 1'b1;
			end
			default: begin
			end
		endcase
		if (s > run_max)
			run_max = s;
		if (s < run_min)
			run_min = s;
		// count and sum freeze once the count is full; the sum clips at its top
		if (run_count != COUNT_MAX) begin
			run_count = run_count + 1'b1;
			wide_sum  = {1'b0, run_sum} + s;
			run_sum   = wide_sum[SUM_BITS] ? SUM_MAX : wide_sum[SUM_BITS-1:0];
		end
		quotient = '0;
		if (run_count != '0)
			quotient = {run_sum, {FRAC_BITS{1'b0}}} / DIV_BITS'(run_count);
		r.sample  = s;
		r.average = quotient[AVG_BITS-1:0];
		r.maximum = run_max;
		r.minimum = run_min;
		r.shown   = run_shown;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errs++;
		end
	endtask

	// compare results first: a result can never belong to an item taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		if (!arst_n) begin
			run_max   = '0;
			run_min   = '0;
			run_sum   = '0;
			run_count = '0;
			run_shown = 1'b0;
			stats_q.delete();
			pending_count <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (stats_q.size() == 0) begin
					$error("result with no item outstanding: current_sample %0d", current_sample);
					errs++;
				end else begin
					want = stats_q.pop_front();
					check_field("current_sample", want.sample, current_sample);
					check_field("average_fixed", want.average, average_fixed);
					check_field("maximum", want.maximum, maximum);
					check_field("minimum", want.minimum, minimum);
					check_field("stats_shown", want.shown, stats_shown);
					checked++;
				end
			end
			if (sample_valid && !sample_stall)
				stats_q.push_back(fold_sample(sample, action));
			error_count   <= errs;
			pending_count <= stats_q.size();
			checked_count <= checked;
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import smmat_pkg::*;

	// the code the block treats as a plain sample
	localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 80;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BLOCKS
	} stall_mode_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic [ACTION_BITS-1:0] action = ACT_SAMPLE;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [SAMPLE_BITS-1:0] current_sample;
	logic [AVG_BITS-1:0]    average_fixed;
	logic [SAMPLE_BITS-1:0] maximum;
	logic [SAMPLE_BITS-1:0] minimum;
	logic                   stats_shown;

	int error_count;
	int pending_count;
	int checked_count;

	int cycle_count = 0;
	int sent_count = 0;
	int restart_count = 0;
	int hide_count = 0;
	int spare_count = 0;
	int burst_left = 0;

	stall_mode_e stall_mode = STALL_NONE;
	int          stall_left = 0;

	sample_min_max_average_tracker_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.action         (action),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.current_sample (current_sample),
		.average_fixed  (average_fixed),
		.maximum        (maximum),
		.minimum        (minimum),
		.stats_shown    (stats_shown)
	);

	tracker_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.action         (action),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.current_sample (current_sample),
		.average_fixed  (average_fixed),
		.maximum        (maximum),
		.minimum        (minimum),
		.stats_shown    (stats_shown),
		.error_count    (error_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// receiver stall pattern: switch between no, light, heavy and blocky stalling
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_left <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 4) != 0);
			default:     result_stall <= (stall_left % 97) < 45;
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_count);
			$display("status: fail");
			$finish;
		end
	end

	// present one item and hold it until the block takes it
	task automatic push_item(input logic [SAMPLE_BITS-1:0] s, input logic [ACTION_BITS-1:0] a);
		sample_valid <= 1'b1;
		sample       <= s;
		action       <= a;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sent_count++;
		case (a)
			ACT_HIDE:    hide_count++;
			ACT_RESTART: restart_count++;
			ACT_SPARE:   spare_count++;
			default: begin
			end
		endcase
	endtask

	// drop valid for a while between bursts
	task automatic pace;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 15);
		end
	endtask

	// hold off the sender until every expected result is back
	task automatic drain;
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	logic [SAMPLE_BITS-1:0] dir_sample [18] = '{
		10'd5, 10'd1023, 10'd0, 10'd700, 10'd512, 10'd1023, 10'd0, 10'd341, 10'd682,
		10'd1, 10'd0, 10'd1023, 10'd1023, 10'd1022, 10'd1, 10'h155, 10'h2AA, 10'd1023
	};
	logic [ACTION_BITS-1:0] dir_action [18] = '{
		ACT_SAMPLE, ACT_SAMPLE, ACT_HIDE, ACT_SPARE, ACT_RESTART, ACT_SAMPLE, ACT_SAMPLE,
		ACT_SPARE, ACT_HIDE, ACT_SAMPLE, ACT_RESTART, ACT_RESTART, ACT_SAMPLE, ACT_SAMPLE,
		ACT_SPARE, ACT_RESTART, ACT_SAMPLE, ACT_HIDE
	};

	initial begin
		int unsigned            pick;
		logic [SAMPLE_BITS-1:0] s;
		logic [ACTION_BITS-1:0] a;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stats before the first restart, extremes, every action code
		for (int i = 0; i < 18; i++) begin
			push_item(dir_sample[i], dir_action[i]);
			pace();
		end
		drain();

		// random runs between restarts, with hides and the spare code mixed in
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain();
			case ($urandom_range(0, 9))
				0:       s = '0;
				1:       s = '1;
				default: s = SAMPLE_BITS'($urandom);
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 6)
				a = ACT_RESTART;
			else if (pick < 12)
				a = ACT_HIDE;
			else if (pick < 16)
				a = ACT_SPARE;
			else
				a = ACT_SAMPLE;
			push_item(s, a);
			pace();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items: %0d restarts, %0d hides, %0d with the spare action code",
			sent_count, restart_count, hide_count, spare_count);
		$display("compared %0d results under random sender gaps and receiver stalls, %0d errors",
			checked_count, error_count);
		if (error_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sample_min_max_average_tracker_unit.f =====
sv/smmat_pkg.sv
sv/smmat_queue.sv
sv/smmat_front.sv
sv/smmat_back.sv
sv/sample_min_max_average_tracker_unit.sv
verif/tracker_checker.sv
verif/tb.sv
